### rtl/core/assert_macros.svh
// shared assertion macros for the rtl folder
// every macro samples on aclk and is disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// label: property must hold at each edge outside reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// label: condition must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

### rtl/core/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg
// Types and constants shared by the slot replacement controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lsr_pkg;

    localparam int PART_W    = 16;
    localparam int BIN_W     = 13;
    localparam int SLOT_IDX_W = 3;

    // bin = part / 10 as (part * 52429) >> 19, exact for all 16-bit parts
    localparam int          DIV_MUL_W = 16;
    localparam int          PROD_W    = PART_W + DIV_MUL_W;
    localparam int          DIV_SHIFT = 19;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 16'd52429;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture part number on input transfer
        logic div;      // register bin number from product
        logic match;    // register tag lookup result
        logic upd;      // write slot state and load result register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free; // result register empty or draining this cycle
    } stat_t;

endpackage

`default_nettype wire

### rtl/core/lsr_ctrl.sv
// ----------------------------------------------------------------------------
// lsr_ctrl
// Sequencer that steps one request through divide, lookup and update.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_ctrl import lsr_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_MATCH = 2'd2;
    localparam logic [1:0] ST_UPD   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = ST_MATCH;
            end
            ST_MATCH: begin
                cmd.match  = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                // hold until the result register can take the new result
                if (stat.out_free) begin
                    cmd.upd    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/lsr_datapath.sv
// ----------------------------------------------------------------------------
// lsr_datapath
// Bin divide, parallel tag match, victim select, LRU list update and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_datapath import lsr_pkg::*; #(
    parameter int SLOTS = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    input  wire logic [PART_W-1:0]     s_part_number,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_hit,
    output logic [SLOT_IDX_W-1:0]      m_slot_index,
    output logic                       m_evicted_valid,
    output logic [BIN_W-1:0]           m_evicted_bin,
    output logic [BIN_W-1:0]           m_bin_number
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [PART_W-1:0]  part_reg;
    logic [BIN_W-1:0]   bin_reg;
    logic [PROD_W-1:0]  prod;

    logic [BIN_W-1:0]   tag_reg   [SLOTS];
    logic [SLOTS-1:0]   valid_reg;
    logic [SLOT_W-1:0]  order_reg [SLOTS];
    logic [SLOT_W-1:0]  order_next[SLOTS];

    logic [SLOTS-1:0]   hit_vec;
    logic [SLOT_W-1:0]  hit_idx;
    logic [SLOT_W-1:0]  free_idx;
    logic               any_free;
    logic [SLOT_W-1:0]  lru_idx;
    logic [SLOT_W-1:0]  sel_next;

    logic               hit_reg;
    logic               ev_reg;
    logic [BIN_W-1:0]   ev_bin_reg;
    logic [SLOT_W-1:0]  sel_reg;

    logic [SLOTS-1:0]   pos_vec;
    logic [SLOT_W-1:0]  pos_idx;
    logic [SLOT_W+SLOT_IDX_W-1:0] sel_ext;

    logic               m_valid_reg;
    logic               m_hit_reg;
    logic [SLOT_IDX_W-1:0] m_slot_reg;
    logic               m_ev_valid_reg;
    logic [BIN_W-1:0]   m_ev_bin_reg;
    logic [BIN_W-1:0]   m_bin_reg;

    // divide by ten via reciprocal multiply
    assign prod = part_reg * DIV_MUL;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            part_reg <= s_part_number;
        end
        if (cmd.div) begin
            bin_reg <= prod[DIV_SHIFT +: BIN_W];
        end
    end

    // tag match and victim choice, lowest slot wins
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i] = valid_reg[i] && (tag_reg[i] == bin_reg);
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = SLOT_W'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
        any_free = ~&valid_reg;
        lru_idx  = order_reg[0];
        if (|hit_vec) begin
            sel_next = hit_idx;
        end else if (any_free) begin
            sel_next = free_idx;
        end else begin
            sel_next = lru_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.match) begin
            hit_reg    <= |hit_vec;
            ev_reg     <= ~(|hit_vec) && !any_free;
            ev_bin_reg <= (~(|hit_vec) && !any_free) ? tag_reg[lru_idx] : '0;
            sel_reg    <= sel_next;
        end
    end

    // move the selected slot to the most recent end of the list
    always_comb begin
        pos_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            pos_vec[i] = (order_reg[i] == sel_reg);
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (pos_vec[i]) begin
                pos_idx = SLOT_W'(i);
            end
        end
        for (int i = 0; i < SLOTS - 1; i++) begin
            order_next[i] = (SLOT_W'(i) >= pos_idx) ? order_reg[i + 1] : order_reg[i];
        end
        order_next[SLOTS-1] = sel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                order_reg[i] <= SLOT_W'(i);
            end
        end else if (cmd.upd) begin
            valid_reg[sel_reg] <= 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                order_reg[i] <= order_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            tag_reg[sel_reg] <= bin_reg;
        end
    end

    // result register, slot number masked to the port width
    assign sel_ext = {{SLOT_IDX_W{1'b0}}, sel_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.upd) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            m_hit_reg      <= hit_reg;
            m_slot_reg     <= sel_ext[SLOT_IDX_W-1:0];
            m_ev_valid_reg <= ev_reg;
            m_ev_bin_reg   <= ev_bin_reg;
            m_bin_reg      <= bin_reg;
        end
    end

    assign stat.out_free   = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_slot_index    = m_slot_reg;
    assign m_evicted_valid = m_ev_valid_reg;
    assign m_evicted_bin   = m_ev_bin_reg;
    assign m_bin_number    = m_bin_reg;

endmodule

`default_nettype wire

### rtl/core/lru_slot_replacement_top.sv
// ----------------------------------------------------------------------------
// lru_slot_replacement_top
// Fully associative LRU slot table keyed by bin number (part number / 10).
// ----------------------------------------------------------------------------
// Each request steps from input transfer to a loaded result as follows: the
// part number is captured, the reciprocal multiplier forms the bin, the
// parallel tag match and victim choice are registered, and the slot table,
// the recency list and the result register are written. A new request is
// taken in the cycle right after the previous update, so no request enters
// while another is in flight; the update waits while the result side is full,
// and the result register lets the next request enter while a result still waits.
// On a hit the slot is reported, on a miss the lowest empty slot is filled,
// and once all slots are valid the least recently used bin is evicted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lru_slot_replacement_top import lsr_pkg::*; #(
    parameter int SLOTS = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [PART_W-1:0]     s_part_number,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_hit,
    output logic [SLOT_IDX_W-1:0]      m_slot_index,
    output logic                       m_evicted_valid,
    output logic [BIN_W-1:0]           m_evicted_bin,
    output logic [BIN_W-1:0]           m_bin_number
);

    cmd_t  cmd;
    stat_t stat;

    lsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lsr_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_part_number   (s_part_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_slot_index    (m_slot_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_bin   (m_evicted_bin),
        .m_bin_number    (m_bin_number)
    );

    // one request in flight: no second transfer right after one
    `ASSERT_PROP(a_one_in_flight, (s_valid && s_ready) |=> !s_ready, "input taken while busy")
    // a hit never evicts
    `ASSERT_NEVER(a_hit_no_evict, m_valid && m_hit && m_evicted_valid, "hit with eviction")
    // an evicted bin missed, so it differs from the requested bin
    `ASSERT_NEVER(a_evict_differs, m_valid && m_evicted_valid && (m_evicted_bin == m_bin_number),
        "evicted bin equals requested bin")
    // result loads only from the update step, which follows a transfer
    `ASSERT_PROP(a_result_source, $rose(m_valid) |-> $past(cmd.upd), "result without update")

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU slot replacement block. A driver sends part
// numbers in bursts while the receiver stalls on its own pattern. A predictor
// keeps its own copy of the slot table and recency list, and the monitor
// compares every result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------

module testbench;
    import lsr_pkg::*;

    localparam int NSLOT       = 5;
    localparam int N_RANDOM    = 1750;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  ev_valid;
        logic [BIN_W-1:0]      ev_bin;
        logic [BIN_W-1:0]      bin;
    } slot_result_t;

    typedef struct {
        logic [PART_W-1:0] part;
        bit                drain_first;
    } part_req_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PART_W-1:0]     s_part_number = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_hit;
    logic [SLOT_IDX_W-1:0] m_slot_index;
    logic                  m_evicted_valid;
    logic [BIN_W-1:0]      m_evicted_bin;
    logic [BIN_W-1:0]      m_bin_number;

    // predictor state
    logic [BIN_W-1:0]      bench_tag [NSLOT];
    logic                  bench_valid [NSLOT];
    logic [SLOT_IDX_W-1:0] lru_list [NSLOT];

    part_req_t    pending_parts[$];
    slot_result_t expected_results[$];

    int  err_count = 0;
    int  result_count = 0;
    int  idle_cycles = 0;
    logic in_xfer = 1'b0;

    // sender burst control
    int burst_left = 0;
    int gap_left = 0;

    // receiver stall control
    int  stall_pct = 0;
    int  phase_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    lru_slot_replacement_top #(.SLOTS(NSLOT)) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_part_number   (s_part_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_slot_index    (m_slot_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_bin   (m_evicted_bin),
        .m_bin_number    (m_bin_number)
    );

    always #5 aclk = ~aclk;

    task automatic clear_bench();
        for (int i = 0; i < NSLOT; i++) begin
            bench_tag[i]   = '0;
            bench_valid[i] = 1'b0;
            lru_list[i]    = SLOT_IDX_W'(i);
        end
    endtask

    // look up one part number and update the slot table and recency list
    task automatic access_bin(input logic [PART_W-1:0] part, output slot_result_t res);
        int  bin_val;
        int  s;
        int  pos;
        bit  found;
        bin_val = int'(part) / 10;
        res = '0;
        res.bin = BIN_W'(bin_val);
        found = 1'b0;
        s = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (!found && bench_valid[i] && bench_tag[i] == BIN_W'(bin_val)) begin
                found = 1'b1;
                s = i;
            end
        end
        res.hit = found;
        if (!found) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!found && !bench_valid[i]) begin
                    found = 1'b1;
                    s = i;
                end
            end
            if (found) begin
                bench_valid[s] = 1'b1;
            end else begin
                // full bench: refill the least recently used slot
                s = int'(lru_list[0]) % NSLOT;
                res.ev_valid = 1'b1;
                res.ev_bin = bench_tag[s];
            end
            bench_tag[s] = BIN_W'(bin_val);
        end
        pos = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (int'(lru_list[i]) == s) pos = i;
        end
        for (int i = pos; i + 1 < NSLOT; i++) begin
            lru_list[i] = lru_list[i + 1];
        end
        lru_list[NSLOT-1] = SLOT_IDX_W'(s);
        res.slot = SLOT_IDX_W'(s);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS) begin
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     result_count, what, got, want);
        end
        err_count++;
    endtask

    task automatic add_part(input int part, input bit drain);
        part_req_t r;
        r.part = PART_W'(part);
        r.drain_first = drain;
        pending_parts.push_back(r);
    endtask

    // input prediction and result checking
    always @(posedge aclk) begin
        slot_result_t pred;
        slot_result_t want;
        if (!aresetn) begin
            in_xfer <= 1'b0;
            clear_bench();
        end else begin
            in_xfer <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                access_bin(s_part_number, pred);
                expected_results.push_back(pred);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_hit !== want.hit)
                        report_mismatch("hit", int'(m_hit), int'(want.hit));
                    if (m_slot_index !== want.slot)
                        report_mismatch("slot_index", int'(m_slot_index), int'(want.slot));
                    if (m_evicted_valid !== want.ev_valid)
                        report_mismatch("evicted_valid", int'(m_evicted_valid),
                                        int'(want.ev_valid));
                    if (m_evicted_bin !== want.ev_bin)
                        report_mismatch("evicted_bin", int'(m_evicted_bin), int'(want.ev_bin));
                    if (m_bin_number !== want.bin)
                        report_mismatch("bin_number", int'(m_bin_number), int'(want.bin));
                end
                result_count++;
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_xfer) begin
            // hold until the transfer happens
        end else if (gap_left > 0) begin
            gap_left--;
            s_valid <= 1'b0;
        end else if (pending_parts.size() == 0) begin
            s_valid <= 1'b0;
        end else if (pending_parts[0].drain_first && expected_results.size() != 0) begin
            s_valid <= 1'b0;
        end else begin
            s_valid <= 1'b1;
            s_part_number <= pending_parts[0].part;
            void'(pending_parts.pop_front());
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    burst_left = $urandom_range(100, 200);
                    gap_left = 0;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = $urandom_range(0, 25);
                end
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && result_count >= 500) begin
            // long hold-off so the block fills and stalls its input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                phase_left = $urandom_range(10, 120);
            end else begin
                phase_left--;
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin
        int pool [8];
        int bin_pick;
        int part;
        int sel;

        // empty bench, bin zero must miss
        add_part(0, 1'b0);
        add_part(9, 1'b0);
        add_part(65535, 1'b0);
        add_part(65530, 1'b0);
        add_part(10, 1'b0);
        add_part(20, 1'b0);
        add_part(30, 1'b0);
        // bench now full, next miss evicts the oldest bin
        add_part(40, 1'b0);
        add_part(5, 1'b0);
        add_part(25, 1'b0);
        add_part(65533, 1'b0);
        add_part(50, 1'b0);
        add_part(60, 1'b0);
        add_part(21, 1'b0);
        add_part(32768, 1'b0);
        add_part(21845, 1'b0);
        add_part(43690, 1'b0);
        add_part(1, 1'b0);
        add_part(65535, 1'b0);
        add_part(20, 1'b0);

        for (int k = 0; k < 8; k++) pool[k] = $urandom_range(0, 6553);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) begin
                for (int k = 0; k < 8; k++) begin
                    if ($urandom_range(0, 1) == 0) pool[k] = $urandom_range(0, 20);
                    else pool[k] = $urandom_range(0, 6553);
                end
            end
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
                // small working set so hits and evictions both occur
                bin_pick = pool[$urandom_range(0, $urandom_range(4, 7))];
                part = bin_pick * 10 + $urandom_range(0, 9);
                if (part > 65535) part = 65535;
            end else if (sel < 95) begin
                part = $urandom_range(0, 65535);
            end else if (sel < 98) begin
                part = $urandom_range(0, 9);
            end else begin
                part = $urandom_range(65530, 65535);
            end
            add_part(part, (n == 0) || (n == 900));
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        do @(posedge aclk);
        while (pending_parts.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (20) @(posedge aclk);

        if (err_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lsr_pkg.sv
rtl/core/lsr_ctrl.sv
rtl/core/lsr_datapath.sv
rtl/core/lru_slot_replacement_top.sv
tb/testbench.sv
